### design/bamm_pkg.sv
// shared types and constants for the lazy barrett modular multiplier
package bamm_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned ModW    = 62;
  localparam int unsigned RatioHW = 63;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [WordW-1:0]   word_t;
  typedef logic [2*WordW-1:0] dword_t;
  typedef logic [HalfW-1:0]   half_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS    = 2'd0,
    CFG_RATIO_HIGH = 2'd1,
    CFG_RATIO_LOW  = 2'd2
  } cfg_idx_t;

  // combine four 32x32 partial products into the full 128-bit product
  function automatic dword_t mul_assemble(word_t p00, word_t p01, word_t p10, word_t p11);
    dword_t lo_hi;
    dword_t mid_a;
    dword_t mid_b;
    lo_hi = {p11, p00};
    mid_a = {{HalfW{1'b0}}, p01, {HalfW{1'b0}}};
    mid_b = {{HalfW{1'b0}}, p10, {HalfW{1'b0}}};
    return lo_hi + mid_a + mid_b;
  endfunction

  // low 64 bits from the low partial product and the two cross terms
  function automatic word_t mul_assemble_lo(word_t p00, half_t p01, half_t p10);
    half_t mid;
    mid = p01 + p10;
    return p00 + {mid, {HalfW{1'b0}}};
  endfunction

endpackage

### design/barrett_lazy_mod_multiply.sv
// lazy barrett modular multiplier, 64-bit operands, nine-stage pipeline
//
// usage:
//   software writes the modulus and the two halves of floor((2^128-1)/modulus)
//   on the cfg_ channel (index 0 modulus, 1 ratio high, 2 ratio low, other
//   indices ignored); cfg_ready is always high. writes belong to idle periods.
//   operand pairs enter on the in_ channel, one item per cycle when the output
//   is not stalled. each item yields one residue, congruent to the product
//   modulo the modulus but not always below it, with the last flag copied.
//   out_valid rises when the item reaches the last stage; throughput is one
//   item per cycle while out_stall is low, as every stage then takes a new item.
//   out_stall holds the output register; the stall then backs up stage by
//   stage, so empty stages still fill and in_stall rises only when all nine
//   stages hold items. nothing is lost or repeated across a stall.
//   reset (rst_n low, synchronous) empties the pipeline and returns the
//   registers to modulus 2, ratio high 2^63-1, ratio low 2^64-1.
module barrett_lazy_mod_multiply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_multiplicand,
  input  logic [63:0] in_multiplier,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_residue,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned NumStages = 9;
  localparam int unsigned HalfW     = bamm_pkg::HalfW;

  // configuration registers
  logic [bamm_pkg::ModW-1:0]    modulus_r;
  logic [bamm_pkg::RatioHW-1:0] ratio_high_r;
  bamm_pkg::word_t              ratio_low_r;

  logic [NumStages-1:0] valid_r;
  logic [NumStages-1:0] stage_en;
  logic [NumStages-1:0] last_r;
  bamm_pkg::word_t      al_r [1:7];

  // stage 0: operand partial products
  bamm_pkg::word_t ap00_r, ap01_r, ap10_r, ap11_r;
  // stage 1: full product halves
  bamm_pkg::word_t ah_r;
  // stage 2: partial products of ah*cl, al*ch and low half of ah*ch
  bamm_pkg::word_t t1p00_r, t1p01_r, t1p10_r, t1p11_r;
  bamm_pkg::word_t t2p00_r, t2p01_r, t2p10_r, t2p11_r;
  bamm_pkg::word_t hh00_r;
  bamm_pkg::half_t hh01_r, hh10_r;
  // stage 3
  bamm_pkg::dword_t t1_r, t2_r;
  bamm_pkg::word_t  ahch3_r;
  // stage 4
  bamm_pkg::word_t sum_hi_r, ahch4_r;
  // stage 5
  bamm_pkg::word_t q_r;
  // stage 6: partial products of modulus*q
  bamm_pkg::word_t mq00_r;
  bamm_pkg::half_t mq01_r, mq10_r;
  // stage 7
  bamm_pkg::word_t mq_lo_r;
  // stage 8
  bamm_pkg::word_t residue_r;

  logic [HalfW-1:0] x0, x1, y0, y1;
  logic [HalfW-1:0] ah0, ah1, al0, al1, cl0, cl1, ch0, ch1, m0, m1, q0, q1;
  bamm_pkg::dword_t prod_nxt;
  bamm_pkg::dword_t sum_nxt;

  assign x0  = in_multiplicand[HalfW-1:0];
  assign x1  = in_multiplicand[63:HalfW];
  assign y0  = in_multiplier[HalfW-1:0];
  assign y1  = in_multiplier[63:HalfW];
  assign ah0 = ah_r[HalfW-1:0];
  assign ah1 = ah_r[63:HalfW];
  assign al0 = al_r[1][HalfW-1:0];
  assign al1 = al_r[1][63:HalfW];
  assign cl0 = ratio_low_r[HalfW-1:0];
  assign cl1 = ratio_low_r[63:HalfW];
  assign ch0 = ratio_high_r[HalfW-1:0];
  assign ch1 = {1'b0, ratio_high_r[bamm_pkg::RatioHW-1:HalfW]};
  assign m0  = modulus_r[HalfW-1:0];
  assign m1  = {2'b00, modulus_r[bamm_pkg::ModW-1:HalfW]};
  assign q0  = q_r[HalfW-1:0];
  assign q1  = q_r[63:HalfW];

  assign prod_nxt = bamm_pkg::mul_assemble(ap00_r, ap01_r, ap10_r, ap11_r);
  assign sum_nxt  = t1_r + t2_r;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    stage_en[NumStages-1] = !valid_r[NumStages-1] || !out_stall;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  assign in_stall     = !stage_en[0];
  assign cfg_ready    = 1'b1;
  assign out_valid    = valid_r[NumStages-1];
  assign out_residue  = residue_r;
  assign out_last_out = last_r[NumStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      modulus_r    <= bamm_pkg::ModW'(2);
      ratio_high_r <= '1;
      ratio_low_r  <= '1;
    end else begin
      if (stage_en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bamm_pkg::CFG_MODULUS:    modulus_r    <= cfg_data[bamm_pkg::ModW-1:0];
          bamm_pkg::CFG_RATIO_HIGH: ratio_high_r <= cfg_data[bamm_pkg::RatioHW-1:0];
          bamm_pkg::CFG_RATIO_LOW:  ratio_low_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      ap00_r    <= x0 * y0;
      ap01_r    <= x0 * y1;
      ap10_r    <= x1 * y0;
      ap11_r    <= x1 * y1;
      last_r[0] <= in_last_in;
    end
    if (stage_en[1]) begin
      ah_r      <= prod_nxt[127:64];
      al_r[1]   <= prod_nxt[63:0];
      last_r[1] <= last_r[0];
    end
    if (stage_en[2]) begin
      t1p00_r   <= ah0 * cl0;
      t1p01_r   <= ah0 * cl1;
      t1p10_r   <= ah1 * cl0;
      t1p11_r   <= ah1 * cl1;
      t2p00_r   <= al0 * ch0;
      t2p01_r   <= al0 * ch1;
      t2p10_r   <= al1 * ch0;
      t2p11_r   <= al1 * ch1;
      hh00_r    <= ah0 * ch0;
      hh01_r    <= HalfW'(ah0 * ch1);
      hh10_r    <= HalfW'(ah1 * ch0);
      al_r[2]   <= al_r[1];
      last_r[2] <= last_r[1];
    end
    if (stage_en[3]) begin
      t1_r      <= bamm_pkg::mul_assemble(t1p00_r, t1p01_r, t1p10_r, t1p11_r);
      t2_r      <= bamm_pkg::mul_assemble(t2p00_r, t2p01_r, t2p10_r, t2p11_r);
      ahch3_r   <= bamm_pkg::mul_assemble_lo(hh00_r, hh01_r, hh10_r);
      al_r[3]   <= al_r[2];
      last_r[3] <= last_r[2];
    end
    if (stage_en[4]) begin
      // middle terms wrap mod 2^128, only the upper half is kept
      sum_hi_r  <= sum_nxt[127:64];
      ahch4_r   <= ahch3_r;
      al_r[4]   <= al_r[3];
      last_r[4] <= last_r[3];
    end
    if (stage_en[5]) begin
      q_r       <= ahch4_r + sum_hi_r;
      al_r[5]   <= al_r[4];
      last_r[5] <= last_r[4];
    end
    if (stage_en[6]) begin
      mq00_r    <= m0 * q0;
      mq01_r    <= HalfW'(m0 * q1);
      mq10_r    <= HalfW'(m1 * q0);
      al_r[6]   <= al_r[5];
      last_r[6] <= last_r[5];
    end
    if (stage_en[7]) begin
      mq_lo_r   <= bamm_pkg::mul_assemble_lo(mq00_r, mq01_r, mq10_r);
      al_r[7]   <= al_r[6];
      last_r[7] <= last_r[6];
    end
    if (stage_en[8]) begin
      residue_r <= al_r[7] - mq_lo_r;
      last_r[8] <= last_r[7];
    end
  end

endmodule

### tb/tb_barrett_lazy_mod_multiply.sv
// testbench for the lazy barrett modular multiplier: predicted residues checked in order
module tb_barrett_lazy_mod_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles = 12;
  localparam int HoldCycles = 60;
  localparam int QuietLimit = 4000;
  localparam int TailCycles = 20;
  localparam int RandomPerSetting = 130;
  localparam int NumSettings = 8;
  localparam int ReportLimit = 10;
  localparam logic [bamm_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam bamm_pkg::word_t AllOnes = '1;

  typedef struct {
    bamm_pkg::word_t multiplicand;
    bamm_pkg::word_t multiplier;
    logic            last_flag;
  } operand_pair_t;

  typedef struct {
    bamm_pkg::word_t residue;
    logic            last_flag;
  } residue_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] in_multiplicand = '0;
  logic [63:0] in_multiplier = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_residue;
  logic out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bamm_pkg::CfgIdxW-1:0] cfg_index = bamm_pkg::CFG_MODULUS;
  logic [63:0] cfg_data = '0;

  // register copy, reset values
  logic [bamm_pkg::ModW-1:0] modulus_q = bamm_pkg::ModW'(2);
  logic [bamm_pkg::RatioHW-1:0] ratio_hi_q = '1;
  bamm_pkg::word_t ratio_lo_q = '1;

  operand_pair_t operand_queue[$];
  residue_t pending_residues[$];
  operand_pair_t next_pair;
  residue_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  barrett_lazy_mod_multiply uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_multiplicand(in_multiplicand),
    .in_multiplier(in_multiplier),
    .in_last_in(in_last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_residue(out_residue),
    .out_last_out(out_last_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // product minus modulus times the estimated quotient, low 64 bits
  function automatic bamm_pkg::word_t lazy_residue(bamm_pkg::word_t x, bamm_pkg::word_t y);
    bamm_pkg::dword_t prod;
    bamm_pkg::dword_t cross_hi;
    bamm_pkg::dword_t cross_lo;
    bamm_pkg::dword_t cross_sum;
    bamm_pkg::word_t quot;
    bamm_pkg::word_t mq_lo;
    prod = bamm_pkg::dword_t'(x) * bamm_pkg::dword_t'(y);
    cross_hi = bamm_pkg::dword_t'(prod[127:64]) * bamm_pkg::dword_t'(ratio_lo_q);
    cross_lo = bamm_pkg::dword_t'(prod[63:0]) * bamm_pkg::dword_t'(ratio_hi_q);
    // wraps at 128 bits before the upper half is taken
    cross_sum = cross_hi + cross_lo;
    quot = bamm_pkg::word_t'(prod[127:64]) * bamm_pkg::word_t'(ratio_hi_q)
           + cross_sum[127:64];
    mq_lo = bamm_pkg::word_t'(modulus_q) * quot;
    return prod[63:0] - mq_lo;
  endfunction

  function automatic bamm_pkg::dword_t ratio_for(bamm_pkg::word_t m);
    bamm_pkg::dword_t all_ones;
    all_ones = '1;
    return all_ones / bamm_pkg::dword_t'(m);
  endfunction

  function automatic bamm_pkg::word_t random_operand();
    case ($urandom_range(7))
      0: return bamm_pkg::word_t'($urandom_range(255));
      1: return AllOnes - bamm_pkg::word_t'($urandom_range(1023));
      2: return bamm_pkg::word_t'(1) << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void push_pair(bamm_pkg::word_t a, bamm_pkg::word_t b, logic l);
    operand_queue.push_back('{a, b, l});
  endfunction

  task automatic report_mismatch(string field, bamm_pkg::word_t exp_val,
                                 bamm_pkg::word_t act_val);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%s mismatch: expected %h, got %h", field, exp_val, act_val);
    end
  endtask

  task automatic write_reg(logic [bamm_pkg::CfgIdxW-1:0] idx, bamm_pkg::word_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bamm_pkg::CFG_MODULUS: modulus_q = data[bamm_pkg::ModW-1:0];
      bamm_pkg::CFG_RATIO_HIGH: ratio_hi_q = data[bamm_pkg::RatioHW-1:0];
      bamm_pkg::CFG_RATIO_LOW: ratio_lo_q = data;
      default: ;
    endcase
  endtask

  task automatic load_setting(bamm_pkg::word_t m_data, bamm_pkg::word_t hi_data,
                              bamm_pkg::word_t lo_data);
    write_reg(bamm_pkg::CFG_MODULUS, m_data);
    write_reg(bamm_pkg::CFG_RATIO_HIGH, hi_data);
    write_reg(bamm_pkg::CFG_RATIO_LOW, lo_data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (operand_queue.size() != 0 || in_valid || pending_residues.size() != 0);
  endtask

  // operand driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_residues.push_back('{lazy_residue(in_multiplicand, in_multiplier),
                                     in_last_in});
      end
      if (!in_valid || !in_stall) begin
        if (operand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pair = operand_queue.pop_front();
          in_valid <= 1'b1;
          in_multiplicand <= next_pair.multiplicand;
          in_multiplier <= next_pair.multiplier;
          in_last_in <= next_pair.last_flag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_residues.size() == 0) begin
          report_mismatch("unexpected item", '0, out_residue);
        end else begin
          want = pending_residues.pop_front();
          if (out_residue !== want.residue) begin
            report_mismatch("residue", want.residue, out_residue);
          end
          if (out_last_out !== want.last_flag) begin
            report_mismatch("last_out", bamm_pkg::word_t'(want.last_flag),
                            bamm_pkg::word_t'(out_last_out));
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int s;
    bamm_pkg::dword_t ratio;
    bamm_pkg::word_t m;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 87;

    // reset registers: modulus 2 with its exact ratio
    push_pair('0, '0, 1'b0);
    push_pair(AllOnes, AllOnes, 1'b1);
    push_pair(AllOnes, 64'd1, 1'b0);
    push_pair(64'd1, AllOnes, 1'b1);
    push_pair('0, AllOnes, 1'b0);
    push_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
    // middle terms overflow 128 bits
    push_pair(AllOnes - 64'd4, AllOnes - 64'd4, 1'b1);
    push_pair(AllOnes - 64'd9, AllOnes - 64'd6, 1'b0);
    push_pair(64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0001, 1'b1);
    push_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_pair(64'd3, 64'd7, 1'b1);
    wait_drained();

    // largest modulus
    m = 64'h3FFF_FFFF_FFFF_FFFF;
    ratio = ratio_for(m);
    load_setting(m, ratio[127:64], ratio[63:0]);
    push_pair(AllOnes, AllOnes, 1'b0);
    push_pair(m, AllOnes, 1'b1);
    push_pair(m - 64'd1, m, 1'b0);
    push_pair(64'h8000_0000_0000_0000, 64'd3, 1'b1);
    push_pair(64'd1, 64'd1, 1'b0);
    push_pair(m + 64'd1, m + 64'd1, 1'b1);
    push_pair(AllOnes - 64'd4, AllOnes - 64'd4, 1'b0);
    wait_drained();

    for (s = 0; s < NumSettings; s++) begin
      case (s)
        0: begin
          ratio = ratio_for(64'd3);
          load_setting(64'd3, ratio[127:64], ratio[63:0]);
        end
        1: begin
          // bits above each register width must be dropped
          m = {2'b00, 30'($urandom), $urandom} | 64'd1;
          ratio = ratio_for(m);
          load_setting(m | 64'hC000_0000_0000_0000,
                       ratio[127:64] | 64'h8000_0000_0000_0000, ratio[63:0]);
        end
        2: load_setting('0, {$urandom, $urandom}, {$urandom, $urandom});
        3: load_setting(64'd1, AllOnes, AllOnes);
        4: begin
          load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
          write_reg(CfgSpare, {$urandom, $urandom});
          write_reg(CfgSpare, AllOnes);
          @(negedge clk);
        end
        5: load_setting(64'd2, '0, '0);
        6: begin
          m = bamm_pkg::word_t'($urandom_range(4, 65535)) & ~64'd1;
          ratio = ratio_for(m);
          load_setting(m, ratio[127:64], ratio[63:0]);
        end
        default: begin
          m = 64'h2000_0000_0000_0001;
          ratio = ratio_for(m);
          load_setting(m, ratio[127:64], ratio[63:0]);
        end
      endcase

      if (s < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 87;
      end else if (s < 6) begin
        send_idle_pct = 87;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold while items keep coming, fills the pipeline
      if (s == 6) hold_request = 1'b1;

      repeat (RandomPerSetting) begin
        push_pair(random_operand(), random_operand(), $urandom_range(7) == 0);
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_residues.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
